### hdl/cgla_pkg.sv
// Shared types and constants for the commit graph lane assigner.
// No dependencies; imported by every module of the block.
`default_nettype none
package cgla_pkg;
  localparam int LANES       = 32;
  localparam int KEY_BITS    = 64;
  localparam int MAX_PARENTS = 4;
  localparam int PAR_LIMIT   = (MAX_PARENTS < 4) ? MAX_PARENTS : 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int CNT_W       = $clog2(LANES + 1);

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CLAIM,
    CMD_ADD,
    CMD_SETKEY,
    CMD_FREE,
    CMD_CLEAR
  } cmd_t;

  // broadcast to every lane cell
  typedef struct packed {
    cmd_t cmd;
    key_t key;
    logic any_hit;
  } lane_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAIM,
    ST_SNAP,
    ST_FIRST,
    ST_EXTRA,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

### hdl/cgla_cell.sv
// One lane cell: waiting key plus busy flag, with hit/free priority chains.
// Depends on cgla_pkg.
`default_nettype none
module cgla_cell import cgla_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lane_op_t op,
  input  wire logic     sel,
  input  wire logic     hit_in,
  input  wire logic     free_in,
  output logic          hit_out,
  output logic          free_out,
  output logic          pick,
  output logic          busy
);
  key_t key;
  logic match;
  logic first_free;

  assign match      = busy && (key == op.key);
  assign first_free = !busy && !free_in;
  assign hit_out    = hit_in | match;
  assign free_out   = free_in | !busy;
  assign pick       = op.any_hit ? (match && !hit_in) : first_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      unique case (op.cmd)
        CMD_CLAIM: begin
          if (op.any_hit) begin
            if (match && hit_in) busy <= 1'b0;
          end else if (first_free) begin
            busy <= 1'b1;
          end
        end
        CMD_ADD:   if (!op.any_hit && first_free) busy <= 1'b1;
        CMD_FREE:  if (sel) busy <= 1'b0;
        CMD_CLEAR: busy <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op.cmd)
      CMD_CLAIM:  if (!op.any_hit && first_free) key <= op.key;
      CMD_ADD:    if (!op.any_hit && first_free) key <= op.key;
      CMD_SETKEY: if (sel) key <= op.key;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### hdl/cgla_row.sv
// Row of lane cells chained from lane 0 upward.
// Depends on cgla_pkg and cgla_cell.
`default_nettype none
module cgla_row import cgla_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lane_op_t         op,
  input  wire logic [LANES-1:0] sel,
  output logic                  any_hit,
  output logic                  any_free,
  output logic [LANES-1:0]      pick,
  output logic [LANES-1:0]      busy
);
  logic [LANES:0] hit_c;
  logic [LANES:0] free_c;

  assign hit_c[0]  = 1'b0;
  assign free_c[0] = 1'b0;

  for (genvar i = 0; i < LANES; i++) begin : g_cell
    cgla_cell u_cell (
      .clk, .rst, .op,
      .sel      (sel[i]),
      .hit_in   (hit_c[i]),
      .free_in  (free_c[i]),
      .hit_out  (hit_c[i+1]),
      .free_out (free_c[i+1]),
      .pick     (pick[i]),
      .busy     (busy[i])
    );
  end

  assign any_hit  = hit_c[LANES];
  assign any_free = free_c[LANES];
endmodule
`default_nettype wire

### hdl/commit_graph_lane_assigner.sv
// Commit graph lane assigner top level: sequencer, snapshot and result register.
// Depends on cgla_pkg and cgla_row.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_ready  | commit_id, num_parents, parent_*, last_commit
//  out     | out_valid/out_ready| column, lane_span, occupied_mask, widest,
//          |                    | lane_overflow
//
// The result is registered after the steps claim, snapshot, first parent, one
// per extra parent and emit, in that order; the extra-parent steps run only
// when the commit got a lane. in_ready returns in the cycle after the emit, so
// a new request is taken only once the previous result has been emitted.
// The lane row is a chain of cells; every step is one broadcast over it.
// in_ready is high only in idle; a full output register stalls the emit step.
// Reset clears all lane busy flags, the widest count and the overflow flag.
`default_nettype none
module commit_graph_lane_assigner import cgla_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [63:0]            commit_id,
  input  wire logic [2:0]             num_parents,
  input  wire logic [63:0]            parent_first,
  input  wire logic [63:0]            parent_second,
  input  wire logic [63:0]            parent_third,
  input  wire logic [63:0]            parent_fourth,
  input  wire logic                   last_commit,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [LANE_W-1:0]           column,
  output logic [CNT_W-1:0]            lane_span,
  output logic [31:0]                 occupied_mask,
  output logic [CNT_W-1:0]            widest,
  output logic                        lane_overflow
);
  state_t state, state_next;

  // latched request
  key_t       id;
  key_t       par [4];
  logic [2:0] pc;
  logic       last;

  // per-request results and log-wide counters
  logic [LANE_W-1:0] col;
  logic [LANES-1:0]  col_oh;
  logic              placed;
  logic [1:0]        pidx;
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0]       mask_r;
  logic [CNT_W-1:0]  widest_seen;
  logic              overflow_seen;

  lane_op_t         op;
  logic [LANES-1:0] sel;
  logic             any_hit, any_free;
  logic [LANES-1:0] pick, busy;

  cgla_row u_row (
    .clk, .rst, .op, .sel,
    .any_hit, .any_free, .pick, .busy
  );

  assign sel = col_oh;

  // index of the picked lane
  logic [LANE_W-1:0] pick_idx;
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < LANES; i++)
      if (pick[i]) pick_idx = pick_idx | LANE_W'(i);
  end

  // snapshot of the row: highest busy lane, mask with the commit's lane forced
  logic [LANE_W-1:0] highest;
  logic [LANES-1:0]  occ;
  logic [CNT_W-1:0]  cnt;
  always_comb begin
    highest = col;
    for (int i = 0; i < LANES; i++)
      if (busy[i] && LANE_W'(i) > highest) highest = LANE_W'(i);
    occ = busy | col_oh | (placed ? '0 : LANES'(1));
    cnt = CNT_W'(highest) + CNT_W'(1);
  end

  logic [31:0] occ32;
  always_comb begin
    occ32 = '0;
    for (int i = 0; i < LANES && i < 32; i++) occ32[i] = occ[i];
  end

  logic emit_go;
  assign emit_go  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    op.cmd      = CMD_NOP;
    op.key      = id;
    op.any_hit  = any_hit;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CLAIM;
      ST_CLAIM: begin
        op.cmd     = CMD_CLAIM;
        state_next = ST_SNAP;
      end
      ST_SNAP:  state_next = ST_FIRST;
      ST_FIRST: begin
        op.key = par[0];
        if (placed) op.cmd = (pc == 3'd0) ? CMD_FREE : CMD_SETKEY;
        state_next = (placed && pc > 3'd1) ? ST_EXTRA : ST_EMIT;
      end
      ST_EXTRA: begin
        op.cmd = CMD_ADD;
        op.key = par[pidx];
        if ({1'b0, pidx} == pc - 3'd1) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_next = ST_IDLE;
          if (last) op.cmd = CMD_CLEAR;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id     <= commit_id[KEY_BITS-1:0];
      par[0] <= parent_first[KEY_BITS-1:0];
      par[1] <= parent_second[KEY_BITS-1:0];
      par[2] <= parent_third[KEY_BITS-1:0];
      par[3] <= parent_fourth[KEY_BITS-1:0];
      pc     <= (num_parents > 3'(PAR_LIMIT)) ? 3'(PAR_LIMIT) : num_parents;
      last   <= last_commit;
    end
  end

  // claim result, snapshot and parent index
  always_ff @(posedge clk) begin
    if (state == ST_CLAIM) begin
      placed <= any_hit | any_free;
      col    <= (any_hit | any_free) ? pick_idx : '0;
      col_oh <= (any_hit | any_free) ? pick : '0;
    end
    if (state == ST_SNAP) begin
      cnt_r  <= cnt;
      mask_r <= occ32;
    end
    if (state == ST_FIRST) pidx <= 2'd1;
    else if (state == ST_EXTRA) pidx <= pidx + 2'd1;
  end

  // log-wide counters
  always_ff @(posedge clk) begin
    if (rst) begin
      widest_seen   <= '0;
      overflow_seen <= 1'b0;
    end else if (emit_go && last) begin
      widest_seen   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (state == ST_CLAIM && !any_hit && !any_free) overflow_seen <= 1'b1;
      if (state == ST_EXTRA && !any_hit && !any_free) overflow_seen <= 1'b1;
      if (state == ST_SNAP && cnt > widest_seen) widest_seen <= cnt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit_go) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      column        <= col;
      lane_span     <= cnt_r;
      occupied_mask <= mask_r;
      widest        <= widest_seen;
      lane_overflow <= overflow_seen;
    end
  end
endmodule
`default_nettype wire

### hdl/cgla_checker.sv
// Port-level checks for the commit graph lane assigner, bound to the top level.
// Depends on cgla_pkg.
`default_nettype none
module cgla_checker import cgla_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [LANE_W-1:0] column,
  input wire logic [CNT_W-1:0]  lane_span,
  input wire logic [31:0]       occupied_mask,
  input wire logic [CNT_W-1:0]  widest
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(column))
    else $error("result dropped while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lane_span > CNT_W'(column))
    else $error("lane span below column");
  a_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupied_mask[column])
    else $error("own lane not in mask");
  a_widest: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> widest >= lane_span)
    else $error("widest below lane span");
endmodule

bind commit_graph_lane_assigner cgla_checker u_cgla_checker (
  .clk, .rst, .out_valid, .out_ready, .column, .lane_span, .occupied_mask, .widest
);
`default_nettype wire
